@@ rtl/irtf_pkg.sv @@
// shared types and constants for the integer radix text formatter
// no dependencies; used by integer_radix_text_formatter
`timescale 1ns / 1ps
`default_nettype none

package irtf_pkg;

    // conversion kinds carried in tuser
    typedef enum logic [2:0] {
        OP_SDEC = 3'd0,
        OP_OCT  = 3'd1,
        OP_UDEC = 3'd2,
        OP_HEXL = 3'd3,
        OP_HEXU = 3'd4
    } op_t;

    localparam int VALUE_W    = 64;
    localparam int OP_W       = 3;
    localparam int WIDTH_W    = 7;
    localparam int PREC_W     = 6;
    localparam int S_TDATA_W  = 88;   // 81 payload bits rounded up to whole bytes
    localparam int M_TDATA_W  = 8;

    localparam int DIG_W      = 4;
    localparam int NUM_DIGITS = 22;   // enough for 64 bits in octal, decimal or hex
    localparam int DIG_IDX_W  = 5;    // index into the digit buffer
    localparam int DCNT_W     = 5;    // digit count 0..22
    localparam int CNT_W      = 7;    // character counts 0..64
    localparam int STEP_W     = 6;    // one step per value bit
    localparam int FIELD_MAX  = 64;

    localparam logic [WIDTH_W-1:0] WIDTH_SAT = WIDTH_W'(FIELD_MAX);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [7:0] DIGITS_LOWER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [7:0] DIGITS_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
        digit_char = upper ? DIGITS_UPPER[d] : DIGITS_LOWER[d];
    endfunction

endpackage

`default_nettype wire

@@ rtl/integer_radix_text_formatter.sv @@
// printf-style integer field formatter (%d %o %u %x %X), one character per output request
// depends on irtf_pkg
`timescale 1ns / 1ps
`default_nettype none

// usage
//  - input channel s_axis: one request per field; tuser carries the conversion kind,
//    tdata carries the value and the format flags (layout at the port list)
//  - output channel m_axis: one request per character; tdata[7:0] is the ascii code,
//    tlast marks the final character of the field; an empty field or an unknown
//    kind produces no output request at all
//  - the block takes one field at a time: s_axis_tready is high only while idle
//  - decimal kinds run a shift-and-adjust binary to bcd conversion, one value bit per
//    cycle; octal and hex split the value into digits at once
//  - after conversion the scan state finds the digit count and the plan state lays out
//    the field (spaces, sign, zeros, digits, trailing spaces)
//  - then one character per cycle is emitted while m_axis_tready stays high
//  - a field is at most 64 characters long
//  - the output register decouples the sides: the next field is accepted while the
//    last character still waits; a stalled receiver simply freezes character output
//  - reset (aresetn low, synchronous) returns to idle and drops any pending output
module integer_radix_text_formatter (
    input  wire                               aclk,
    input  wire                               aresetn,
    // value_bits[63:0], force_plus[64], left_justify[65], zero_fill[66],
    // min_width[73:67], digit_precision[79:74], has_precision[80], zeros above
    input  wire  [irtf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // op[2:0]
    input  wire  [irtf_pkg::OP_W-1:0]         s_axis_tuser,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // out_char[7:0]
    output logic [irtf_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // last_char
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_PLAN,
        ST_EMIT
    } state_t;

    // sequencer and field description
    state_t                             state_reg, state_next;
    logic [irtf_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [irtf_pkg::VALUE_W-1:0]       val_reg, val_next;      // magnitude being shifted into bcd
    logic [irtf_pkg::DIG_W-1:0]         dig_reg  [irtf_pkg::NUM_DIGITS];
    logic [irtf_pkg::DIG_W-1:0]         dig_next [irtf_pkg::NUM_DIGITS];
    logic                               neg_reg, neg_next;
    logic                               has_sign_reg, has_sign_next;
    logic                               upper_reg, upper_next;
    logic                               left_reg, left_next;
    logic                               zfill_reg, zfill_next;
    logic                               hasp_reg, hasp_next;
    logic [irtf_pkg::WIDTH_W-1:0]       width_reg, width_next;  // already saturated to 64
    logic [irtf_pkg::PREC_W-1:0]        prec_reg, prec_next;
    logic [irtf_pkg::DCNT_W-1:0]        ndig_reg, ndig_next;

    // remaining characters in each segment, emitted in this order
    logic [irtf_pkg::CNT_W-1:0]         lsp_reg, lsp_next;      // leading spaces
    logic                               sgn_reg, sgn_next;      // sign character
    logic [irtf_pkg::CNT_W-1:0]         lz_reg, lz_next;        // pad zeros plus precision zeros
    logic [irtf_pkg::DCNT_W-1:0]        dcnt_reg, dcnt_next;    // digits, most significant first
    logic [irtf_pkg::CNT_W-1:0]         tsp_reg, tsp_next;      // trailing spaces
    logic [irtf_pkg::CNT_W-1:0]         rem_reg, rem_next;      // characters left in the field

    // output register
    logic                               ovalid_reg, ovalid_next;
    logic [irtf_pkg::M_TDATA_W-1:0]     ochar_reg, ochar_next;
    logic                               olast_reg, olast_next;

    // input field view
    logic [irtf_pkg::VALUE_W-1:0]       in_value;
    irtf_pkg::op_t                      in_op;
    logic                               in_plus, in_left, in_zfill, in_hasp;
    logic [irtf_pkg::WIDTH_W-1:0]       in_width;
    logic [irtf_pkg::PREC_W-1:0]        in_prec;

    logic                               in_fire;
    logic                               produce;

    assign in_value = s_axis_tdata[63:0];
    assign in_op    = irtf_pkg::op_t'(s_axis_tuser);
    assign in_plus  = s_axis_tdata[64];
    assign in_left  = s_axis_tdata[65];
    assign in_zfill = s_axis_tdata[66];
    assign in_width = s_axis_tdata[73:67];
    assign in_prec  = s_axis_tdata[79:74];
    assign in_hasp  = s_axis_tdata[80];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign produce       = (state_reg == ST_EMIT) && (!ovalid_reg || m_axis_tready);

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ochar_reg;
    assign m_axis_tlast  = olast_reg;

    always_comb begin
        logic                               in_neg;
        logic [irtf_pkg::VALUE_W-1:0]       in_mag;
        logic [irtf_pkg::VALUE_W+1:0]       oct_src;
        logic [irtf_pkg::DIG_W-1:0]         adj [irtf_pkg::NUM_DIGITS];
        logic [irtf_pkg::NUM_DIGITS-1:0]    nz;
        logic [irtf_pkg::DCNT_W-1:0]        top;
        logic [irtf_pkg::PREC_W-1:0]        base_w;
        logic [irtf_pkg::PREC_W-1:0]        zeros_w;
        logic [irtf_pkg::CNT_W-1:0]         pad_w;
        logic [irtf_pkg::CNT_W-1:0]         pad_s_w;
        logic [irtf_pkg::CNT_W:0]           total_w;
        logic [irtf_pkg::DIG_IDX_W-1:0]     didx;

        state_next    = state_reg;
        step_next     = step_reg;
        val_next      = val_reg;
        dig_next      = dig_reg;
        neg_next      = neg_reg;
        has_sign_next = has_sign_reg;
        upper_next    = upper_reg;
        left_next     = left_reg;
        zfill_next    = zfill_reg;
        hasp_next     = hasp_reg;
        width_next    = width_reg;
        prec_next     = prec_reg;
        ndig_next     = ndig_reg;
        lsp_next      = lsp_reg;
        sgn_next      = sgn_reg;
        lz_next       = lz_reg;
        dcnt_next     = dcnt_reg;
        tsp_next      = tsp_reg;
        rem_next      = rem_reg;
        ovalid_next   = ovalid_reg;
        ochar_next    = ochar_reg;
        olast_next    = olast_reg;

        in_neg  = (in_op == irtf_pkg::OP_SDEC) && in_value[irtf_pkg::VALUE_W-1];
        in_mag  = in_neg ? (irtf_pkg::VALUE_W'(0) - in_value) : in_value;
        oct_src = {2'b00, in_value};

        // add 3 to every bcd digit of 5 or more before the shift
        for (int i = 0; i < irtf_pkg::NUM_DIGITS; i++) begin
            adj[i] = (dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end

        top = '0;
        for (int i = 0; i < irtf_pkg::NUM_DIGITS; i++) begin
            nz[i] = (dig_reg[i] != '0);
            if (nz[i]) begin
                top = irtf_pkg::DCNT_W'(i + 1);
            end
        end

        base_w  = ({1'b0, ndig_reg} > prec_reg) ? {1'b0, ndig_reg} : prec_reg;
        zeros_w = base_w - {1'b0, ndig_reg};
        pad_w   = (width_reg > {1'b0, base_w}) ? width_reg - {1'b0, base_w} : '0;
        pad_s_w = (pad_w > {6'd0, has_sign_reg}) ? pad_w - {6'd0, has_sign_reg} : '0;
        total_w = '0;

        didx = dcnt_reg - 5'd1;

        if (m_axis_tready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    neg_next      = in_neg;
                    has_sign_next = in_neg || ((in_op == irtf_pkg::OP_SDEC) && in_plus);
                    upper_next    = (in_op == irtf_pkg::OP_HEXU);
                    left_next     = in_left;
                    zfill_next    = in_zfill;
                    hasp_next     = in_hasp;
                    width_next    = (in_width > irtf_pkg::WIDTH_SAT) ? irtf_pkg::WIDTH_SAT
                                                                     : in_width;
                    prec_next     = in_prec;
                    val_next      = in_mag;
                    step_next     = '0;
                    case (in_op) inside
                        irtf_pkg::OP_SDEC, irtf_pkg::OP_UDEC: begin
                            for (int i = 0; i < irtf_pkg::NUM_DIGITS; i++) begin
                                dig_next[i] = '0;
                            end
                            state_next = ST_CONV;
                        end
                        irtf_pkg::OP_OCT: begin
                            for (int i = 0; i < irtf_pkg::NUM_DIGITS; i++) begin
                                dig_next[i] = {1'b0, oct_src[3*i +: 3]};
                            end
                            state_next = ST_SCAN;
                        end
                        irtf_pkg::OP_HEXL, irtf_pkg::OP_HEXU: begin
                            for (int i = 0; i < irtf_pkg::NUM_DIGITS; i++) begin
                                dig_next[i] = (i < 16) ? in_value[(4*i) % 64 +: 4] : '0;
                            end
                            state_next = ST_SCAN;
                        end
                        default: begin
                            // unknown kind: field is dropped
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CONV: begin
                dig_next[0] = {adj[0][2:0], val_reg[irtf_pkg::VALUE_W-1]};
                for (int i = 1; i < irtf_pkg::NUM_DIGITS; i++) begin
                    dig_next[i] = {adj[i][2:0], adj[i-1][3]};
                end
                val_next  = {val_reg[irtf_pkg::VALUE_W-2:0], 1'b0};
                step_next = step_reg + 6'd1;
                if (step_reg == '1) begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (nz == '0) begin
                    // zero prints one digit unless an explicit precision of zero asks for none
                    ndig_next = (hasp_reg && (prec_reg == '0)) ? 5'd0 : 5'd1;
                end else begin
                    ndig_next = top;
                end
                state_next = ST_PLAN;
            end

            ST_PLAN: begin
                sgn_next  = has_sign_reg;
                dcnt_next = ndig_reg;
                if (left_reg) begin
                    lsp_next = '0;
                    lz_next  = {1'b0, zeros_w};
                    tsp_next = pad_s_w;
                end else if (zfill_reg && (pad_w != '0)) begin
                    lsp_next = '0;
                    lz_next  = pad_s_w + {1'b0, zeros_w};
                    tsp_next = '0;
                end else begin
                    lsp_next = pad_s_w;
                    lz_next  = {1'b0, zeros_w};
                    tsp_next = '0;
                end
                total_w = {1'b0, lsp_next} + {7'd0, sgn_next} + {1'b0, lz_next}
                        + {3'd0, dcnt_next} + {1'b0, tsp_next};
                rem_next   = total_w[irtf_pkg::CNT_W-1:0];
                state_next = (total_w == '0) ? ST_IDLE : ST_EMIT;
            end

            ST_EMIT: begin
                if (produce) begin
                    ovalid_next = 1'b1;
                    olast_next  = (rem_reg == 7'd1);
                    rem_next    = rem_reg - 7'd1;
                    if (lsp_reg != '0) begin
                        ochar_next = irtf_pkg::CHAR_SPACE;
                        lsp_next   = lsp_reg - 7'd1;
                    end else if (sgn_reg) begin
                        ochar_next = neg_reg ? irtf_pkg::CHAR_MINUS : irtf_pkg::CHAR_PLUS;
                        sgn_next   = 1'b0;
                    end else if (lz_reg != '0) begin
                        ochar_next = irtf_pkg::CHAR_ZERO;
                        lz_next    = lz_reg - 7'd1;
                    end else if (dcnt_reg != '0) begin
                        ochar_next = irtf_pkg::digit_char(dig_reg[didx], upper_reg);
                        dcnt_next  = dcnt_reg - 5'd1;
                    end else begin
                        ochar_next = irtf_pkg::CHAR_SPACE;
                        tsp_next   = tsp_reg - 7'd1;
                    end
                    if (rem_reg == 7'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            rem_reg    <= '0;
            lsp_reg    <= '0;
            sgn_reg    <= 1'b0;
            lz_reg     <= '0;
            dcnt_reg   <= '0;
            tsp_reg    <= '0;
            step_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            rem_reg    <= rem_next;
            lsp_reg    <= lsp_next;
            sgn_reg    <= sgn_next;
            lz_reg     <= lz_next;
            dcnt_reg   <= dcnt_next;
            tsp_reg    <= tsp_next;
            step_reg   <= step_next;
        end
        val_reg      <= val_next;
        dig_reg      <= dig_next;
        neg_reg      <= neg_next;
        has_sign_reg <= has_sign_next;
        upper_reg    <= upper_next;
        left_reg     <= left_next;
        zfill_reg    <= zfill_next;
        hasp_reg     <= hasp_next;
        width_reg    <= width_next;
        prec_reg     <= prec_next;
        ndig_reg     <= ndig_next;
        ochar_reg    <= ochar_next;
        olast_reg    <= olast_next;
    end

    // while emitting, the character budget matches the sum of the open segments
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |->
            ({1'b0, rem_reg} == ({1'b0, lsp_reg} + {7'd0, sgn_reg} + {1'b0, lz_reg}
                               + {3'd0, dcnt_reg} + {1'b0, tsp_reg})))
        else $error("segment counts disagree with remaining characters");

    // a field never runs past 64 characters and never emits from an empty budget
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ((rem_reg != '0) && (rem_reg <= 7'd64)))
        else $error("remaining character count out of range");

    // the final character of a field returns the sequencer to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && (rem_reg == 7'd1)) |=> (state_reg == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
        else $error("last character did not end the field");

endmodule

`default_nettype wire
